[src/gdcq_pkg.sv]
// Shared types, constants and calendar tables for the Gregorian date query block.
// Used by every module under src; no dependencies of its own.

package gdcq_pkg;

	// Field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int DOW_W    = 3;
	localparam int MEND_W   = 5;
	localparam int YEND_W   = 9;
	localparam int QY_W     = 8;   // year / 100 for a 14-bit year
	localparam int SHY_W    = 15;  // year + 400
	localparam int SUM_W    = 15;  // weekday sum before mod 7
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int PROD_W      = 27;

	// year / 100 == (year * 5243) >> 19, exact for year < 16784
	localparam int RECIP_100  = 5243;
	localparam int RECIP_SHFT = 19;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WEEKEND_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_DAY     = 2'd1;

	localparam logic [6:0] WEEKEND_MASK_RST = 7'd96;
	localparam logic [2:0] LAST_DAY_RST     = 3'd6;
	localparam logic [2:0] SATURDAY         = 3'd6;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} date_t;

	typedef struct packed {
		logic [6:0] weekend_mask;
		logic [2:0] last_day;
	} cfg_t;

	// After the quotient stage
	typedef struct packed {
		date_t           date;
		logic [QY_W-1:0] qy;
	} quot_t;

	// After the sum stage
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic              invalid;
		logic [MEND_W-1:0] month_end;
		logic [YEND_W-1:0] year_end;
	} calc_t;

	typedef struct packed {
		logic [YEND_W-1:0] days_to_year_end;
		logic [MEND_W-1:0] days_to_month_end;
		logic [DOW_W-1:0]  days_to_week_end;
		logic              is_business_day;
		logic              is_weekend;
		logic              is_end_of_week;
		logic [DOW_W-1:0]  day_of_week;
	} result_t;

	// Days in month; zero for a month code outside 1..12
	function automatic logic [MEND_W-1:0] month_len(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [MEND_W-1:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:    len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the months before this one, common year
	function automatic logic [YEND_W-1:0] days_before(input logic [MONTH_W-1:0] month);
		logic [YEND_W-1:0] d;
		case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// (31 * m) / 12 with m the March-based month (Jan, Feb are 11, 12)
	function automatic logic [4:0] month_term(input logic [MONTH_W-1:0] month);
		logic [4:0] t;
		case (month)
			4'd1:    t = 5'd28;
			4'd2:    t = 5'd31;
			4'd3:    t = 5'd2;
			4'd4:    t = 5'd5;
			4'd5:    t = 5'd7;
			4'd6:    t = 5'd10;
			4'd7:    t = 5'd12;
			4'd8:    t = 5'd15;
			4'd9:    t = 5'd18;
			4'd10:   t = 5'd20;
			4'd11:   t = 5'd23;
			4'd12:   t = 5'd25;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

endpackage

[src/gregorian_date_calendar_query.sv]
// Top level of the Gregorian date query: input register, configuration registers
// and three pipeline stages. Depends on gdcq_pkg, gdcq_quot_stage,
// gdcq_calc_stage and gdcq_out_stage.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  s_axis   | in        | s_tvalid / s_tready    | s_tdata: year, month, day
//  m_axis   | out       | m_tvalid / m_tready    | m_tdata: week/month/year results
//           |           |                        | m_tuser: date_invalid
//  cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One date per cycle sustained while m_tready stays high; each beat passes the
// input register, quotient stage, sum stage and result register in that order.
// Each stage holds its beat while the next one is full, so stalls on m_tready
// back up one stage at a time. Reset clears the valid bits and loads the
// configuration defaults (weekend Fri/Sat, week ends Saturday). Config is
// always ready.

module gregorian_date_calendar_query (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [13:0] year, [17:14] month, [22:18] day, [23] zero
	input  logic [gdcq_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [2:0] day_of_week, [3] is_end_of_week, [4] is_weekend, [5] is_business_day,
	// [8:6] days_to_week_end, [13:9] days_to_month_end, [22:14] days_to_year_end,
	// [23] zero
	output logic [gdcq_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// [0] date_invalid
	output logic                                 m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gdcq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gdcq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	gdcq_pkg::date_t   date_s1;
	logic              vld_s1;
	logic              quot_ready;
	logic              quot_valid;
	gdcq_pkg::quot_t   quot;
	logic              calc_ready;
	logic              calc_valid;
	gdcq_pkg::calc_t   calc;
	logic              out_ready_int;
	gdcq_pkg::cfg_t    cfg_q;
	gdcq_pkg::result_t result;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weekend_mask <= gdcq_pkg::WEEKEND_MASK_RST;
			cfg_q.last_day     <= gdcq_pkg::LAST_DAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gdcq_pkg::CFG_WEEKEND_MASK: cfg_q.weekend_mask <= cfg_data;
				gdcq_pkg::CFG_LAST_DAY:     cfg_q.last_day     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Input register
	assign s_tready = !vld_s1 || quot_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			date_s1.year  <= s_tdata[13:0];
			date_s1.month <= s_tdata[17:14];
			date_s1.day   <= s_tdata[22:18];
		end
	end

	gdcq_quot_stage u_quot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (quot_ready),
		.in_date   (date_s1),
		.out_valid (quot_valid),
		.out_ready (calc_ready),
		.out_quot  (quot)
	);

	gdcq_calc_stage u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (quot_valid),
		.in_ready  (calc_ready),
		.in_quot   (quot),
		.out_valid (calc_valid),
		.out_ready (out_ready_int),
		.out_calc  (calc)
	);

	gdcq_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (calc_valid),
		.in_ready    (out_ready_int),
		.in_calc     (calc),
		.cfg         (cfg_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_result  (result),
		.out_invalid (m_tuser)
	);

	// Result beat packing
	assign m_tdata = {1'b0, result};

endmodule

[src/gdcq_quot_stage.sv]
// Pipeline stage: year / 100 by reciprocal multiply, registered.
// Depends on gdcq_pkg.

module gdcq_quot_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gdcq_pkg::date_t in_date,
	output logic           out_valid,
	input  logic           out_ready,
	output gdcq_pkg::quot_t out_quot
);

	logic [gdcq_pkg::PROD_W-1:0] prod;
	gdcq_pkg::quot_t             quot_s2;
	logic                        vld_s2;

	// Reciprocal multiply, quotient is the top bits
	assign prod = gdcq_pkg::PROD_W'(in_date.year) * gdcq_pkg::PROD_W'(gdcq_pkg::RECIP_100);

	assign in_ready = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			quot_s2.date <= in_date;
			quot_s2.qy   <= prod[gdcq_pkg::RECIP_SHFT +: gdcq_pkg::QY_W];
		end
	end

	assign out_valid = vld_s2;
	assign out_quot  = quot_s2;

endmodule

[src/gdcq_calc_stage.sv]
// Pipeline stage: leap year, validity, month/year remaining days, weekday sum.
// Depends on gdcq_pkg.

module gdcq_calc_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gdcq_pkg::quot_t in_quot,
	output logic            out_valid,
	input  logic            out_ready,
	output gdcq_pkg::calc_t out_calc
);

	logic [gdcq_pkg::YEAR_W-1:0]  year;
	logic [gdcq_pkg::MONTH_W-1:0] month;
	logic [gdcq_pkg::DAY_W-1:0]   day;
	logic [gdcq_pkg::YEAR_W-1:0]  rem_full;
	logic                         century;
	logic                         leap;
	logic [gdcq_pkg::MEND_W-1:0]  dim;
	logic                         invalid;
	logic                         early;     // January or February
	logic [gdcq_pkg::SHY_W-1:0]   ysh;
	logic [gdcq_pkg::QY_W-1:0]    q100;
	logic [gdcq_pkg::QY_W-1:0]    q400;
	logic [gdcq_pkg::SUM_W-1:0]   sum;
	logic [gdcq_pkg::YEND_W-1:0]  doy;
	logic [gdcq_pkg::YEND_W-1:0]  diy;
	gdcq_pkg::calc_t              nxt;
	gdcq_pkg::calc_t              calc_s3;
	logic                         vld_s3;

	assign year  = in_quot.date.year;
	assign month = in_quot.date.month;
	assign day   = in_quot.date.day;

	// Leap year: year % 100 from the registered quotient
	assign rem_full = year - (gdcq_pkg::YEAR_W'(in_quot.qy) * 14'd100);
	assign century  = (rem_full == '0);
	assign leap     = ((year[1:0] == 2'b00) && !century) ||
	                  (century && (in_quot.qy[1:0] == 2'b00));

	// Validity
	assign dim     = gdcq_pkg::month_len(month, leap);
	assign invalid = (dim == '0) || (day == '0) || (day > dim);

	// Shifted-month weekday sum; y = year + 400 - early
	assign early = (month == 4'd1) || (month == 4'd2);
	assign ysh   = gdcq_pkg::SHY_W'(year) + 15'd400 - gdcq_pkg::SHY_W'(early);
	assign q100  = in_quot.qy + 8'd4 - gdcq_pkg::QY_W'(early && century);
	assign q400  = {2'b00, q100[gdcq_pkg::QY_W-1:2]};
	assign sum   = gdcq_pkg::SUM_W'(day) + ysh + {2'b00, ysh[gdcq_pkg::SHY_W-1:2]}
	             - gdcq_pkg::SUM_W'(q100) + gdcq_pkg::SUM_W'(q400)
	             + gdcq_pkg::SUM_W'(gdcq_pkg::month_term(month));

	// Day of year and days left
	assign doy = gdcq_pkg::days_before(month) + gdcq_pkg::YEND_W'(day)
	           + gdcq_pkg::YEND_W'(leap && (month > 4'd2));
	assign diy = leap ? 9'd366 : 9'd365;

	always_comb begin
		nxt.sum       = sum;
		nxt.invalid   = invalid;
		nxt.month_end = invalid ? '0 : (dim - day + 5'd1);
		nxt.year_end  = invalid ? '0 : (diy - doy + 9'd1);
	end

	assign in_ready = !vld_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			calc_s3 <= nxt;
		end
	end

	assign out_valid = vld_s3;
	assign out_calc  = calc_s3;

endmodule

[src/gdcq_out_stage.sv]
// Output stage: weekday mod 7, week flags from configuration, result register.
// Depends on gdcq_pkg.

module gdcq_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gdcq_pkg::calc_t   in_calc,
	input  gdcq_pkg::cfg_t    cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output gdcq_pkg::result_t out_result,
	output logic              out_invalid
);

	logic [5:0]                 fold1;
	logic [3:0]                 fold2;
	logic [2:0]                 fold3;
	logic [gdcq_pkg::DOW_W-1:0] dow;
	logic [2:0]                 last;
	logic                       weekend;
	gdcq_pkg::result_t          nxt;
	gdcq_pkg::result_t          res_q;
	logic                       inv_q;
	logic                       vld_q;

	// mod 7 by summing octal digits (8 == 1 mod 7)
	assign fold1 = 6'(in_calc.sum[2:0]) + 6'(in_calc.sum[5:3]) + 6'(in_calc.sum[8:6])
	             + 6'(in_calc.sum[11:9]) + 6'(in_calc.sum[14:12]);
	assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
	assign fold3 = fold2[2:0] + 3'(fold2[3]);
	assign dow   = (fold3 == 3'd7) ? 3'd0 : fold3;

	assign last    = (cfg.last_day > gdcq_pkg::SATURDAY) ? gdcq_pkg::SATURDAY : cfg.last_day;
	assign weekend = cfg.weekend_mask[dow];

	always_comb begin
		nxt = '0;
		if (!in_calc.invalid) begin
			nxt.day_of_week       = dow;
			nxt.is_end_of_week    = (dow == last);
			nxt.is_weekend        = weekend;
			nxt.is_business_day   = !weekend;
			nxt.days_to_week_end  = (last >= dow) ? (last - dow) : (last + 3'd7 - dow);
			nxt.days_to_month_end = in_calc.month_end;
			nxt.days_to_year_end  = in_calc.year_end;
		end
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= nxt;
			inv_q <= in_calc.invalid;
		end
	end

	assign out_valid   = vld_q;
	assign out_result  = res_q;
	assign out_invalid = inv_q;

endmodule

[tb/tb_gregorian_date_calendar_query.sv]
// Self-checking bench for gregorian_date_calendar_query: date beats in, calendar answers out,
// checked in order against known answers or an in-bench predictor across register settings.
// Depends on gdcq_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb_gregorian_date_calendar_query;

	localparam int ROWS_PER_PHASE = 190;
	localparam int NUM_PHASES     = 6;
	localparam int STALL_CYCLES   = 200;
	localparam int PIPE_SETTLE    = 8;
	localparam int MAX_REPORTS    = 10;
	// indexes with no register behind them
	localparam logic [gdcq_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
	localparam logic [gdcq_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;

	typedef struct packed {
		logic              invalid;
		gdcq_pkg::result_t res;
	} answer_t;

	typedef struct {
		gdcq_pkg::date_t d;
		answer_t         a;
	} due_t;

	typedef struct {
		gdcq_pkg::date_t d;
		bit              known;
		answer_t         a;
	} dir_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [gdcq_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [gdcq_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             m_tuser;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [gdcq_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [gdcq_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// predictor copy of the registers
	logic [6:0] wk_mask = gdcq_pkg::WEEKEND_MASK_RST;
	logic [2:0] wk_last = gdcq_pkg::LAST_DAY_RST;

	due_t     answers_due[$];
	dir_row_t dir_rows[$];
	int       err_cnt = 0;
	int       tx_idle_pct = 0;
	int       rx_idle_pct = 0;
	bit       stall_req = 1'b0;
	int       stall_left = 0;

	gregorian_date_calendar_query uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Calendar helpers
	function automatic bit is_leap(input int unsigned yr);
		return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
	endfunction

	function automatic int unsigned month_days(input int unsigned mo, input bit lp);
		case (mo)
			2:             return lp ? 29 : 28;
			4, 6, 9, 11:   return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default:       return 0;
		endcase
	endfunction

	// Expected answer for one date under the current register copy
	function automatic answer_t predict_query(input gdcq_pkg::date_t d);
		answer_t     e;
		int unsigned yr, mo, dy, dim, shift, ys, ms, dow, last, doy, diy;
		bit          lp;
		e  = '0;
		yr = d.year;
		mo = d.month;
		dy = d.day;
		lp = is_leap(yr);
		dim = month_days(mo, lp);
		if (dim == 0 || dy == 0 || dy > dim) begin
			e.invalid = 1'b1;
			return e;
		end
		// March-based year so the leap day falls at the end
		shift = (mo <= 2) ? 1 : 0;
		ys  = yr + 400 - shift;
		ms  = mo + 12 * shift - 2;
		dow = (dy + ys + ys / 4 - ys / 100 + ys / 400 + (31 * ms) / 12) % 7;
		last = (wk_last > 6) ? 6 : wk_last;
		doy = dy;
		for (int k = 1; k < mo; k++) doy += month_days(k, lp);
		diy = lp ? 366 : 365;
		e.res.day_of_week       = gdcq_pkg::DOW_W'(dow);
		e.res.is_end_of_week    = (dow == last);
		e.res.is_weekend        = wk_mask[dow];
		e.res.is_business_day   = ~wk_mask[dow];
		e.res.days_to_week_end  = gdcq_pkg::DOW_W'((last + 7 - dow) % 7);
		e.res.days_to_month_end = gdcq_pkg::MEND_W'(dim - dy + 1);
		e.res.days_to_year_end  = gdcq_pkg::YEND_W'(diy - doy + 1);
		return e;
	endfunction

	// Mostly well-formed dates, weighted toward the month edges, some noise
	function automatic gdcq_pkg::date_t random_date();
		gdcq_pkg::date_t d;
		int unsigned     yr, mo, last;
		int              pick;
		pick = $urandom_range(99);
		if (pick < 12) begin
			d.year  = gdcq_pkg::YEAR_W'($urandom_range(16383));
			d.month = gdcq_pkg::MONTH_W'($urandom_range(15));
			d.day   = gdcq_pkg::DAY_W'($urandom_range(31));
			return d;
		end
		pick = $urandom_range(19);
		if (pick == 0)
			yr = $urandom_range(1) ? 0 : $urandom_range(16383, 10000);
		else if (pick == 1)
			yr = 100 * $urandom_range(163);
		else
			yr = $urandom_range(9999, 1);
		mo   = $urandom_range(12, 1);
		last = month_days(mo, is_leap(yr));
		pick = $urandom_range(9);
		d.year  = gdcq_pkg::YEAR_W'(yr);
		d.month = gdcq_pkg::MONTH_W'(mo);
		case (pick)
			0:       d.day = gdcq_pkg::DAY_W'(1);
			1:       d.day = gdcq_pkg::DAY_W'(last);
			2:       d.day = gdcq_pkg::DAY_W'(last + 1);
			3:       d.day = '0;
			default: d.day = gdcq_pkg::DAY_W'($urandom_range(last, 1));
		endcase
		return d;
	endfunction

	task automatic row_pred(input int yr, input int mo, input int dy);
		dir_row_t r;
		r.d     = {gdcq_pkg::DAY_W'(dy), gdcq_pkg::MONTH_W'(mo), gdcq_pkg::YEAR_W'(yr)};
		r.known = 1'b0;
		r.a     = '0;
		dir_rows.push_back(r);
	endtask

	task automatic row_known(input int yr, input int mo, input int dy, input logic inv,
		input gdcq_pkg::result_t res);
		dir_row_t r;
		r.d     = {gdcq_pkg::DAY_W'(dy), gdcq_pkg::MONTH_W'(mo), gdcq_pkg::YEAR_W'(yr)};
		r.known = 1'b1;
		r.a     = {inv, res};
		dir_rows.push_back(r);
	endtask

	// Offer one date beat; called and returns at a falling edge
	task automatic send_date(input gdcq_pkg::date_t d, input bit known, input answer_t ans);
		due_t n;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, d};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n.d = d;
		n.a = known ? ans : predict_query(d);
		answers_due.push_back(n);
		@(negedge clk);
	endtask

	// Register write beat; cfg_valid is left high for back-to-back writes
	task automatic write_reg(input logic [gdcq_pkg::CFG_IDX_W-1:0] idx,
		input logic [gdcq_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == gdcq_pkg::CFG_WEEKEND_MASK)
			wk_mask = val;
		else if (idx == gdcq_pkg::CFG_LAST_DAY)
			wk_last = val[2:0];
		@(negedge clk);
	endtask

	// Wait for all answers plus pipeline settle; returns at a falling edge
	task automatic wait_drain();
		while (answers_due.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: random back-pressure, plus a long hold-off on request
	always @(negedge clk) begin
		if (stall_req) begin
			stall_left = STALL_CYCLES;
			stall_req  = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Output checker
	always @(posedge clk) begin
		due_t              want;
		gdcq_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(gdcq_pkg::result_t)-1:0];
			if (answers_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("unexpected answer beat tdata=%h tuser=%b", m_tdata, m_tuser);
			end else begin
				want = answers_due.pop_front();
				if ({m_tuser, m_tdata} !== {want.a.invalid, 1'b0, want.a.res}) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("mismatch for %0d-%0d-%0d (y-m-d)", want.d.year,
							want.d.month, want.d.day);
						$display("  want dow=%0d eow=%b wkend=%b biz=%b",
							want.a.res.day_of_week, want.a.res.is_end_of_week,
							want.a.res.is_weekend, want.a.res.is_business_day);
						$display("       to_wk=%0d to_mo=%0d to_yr=%0d inv=%b pad=0",
							want.a.res.days_to_week_end, want.a.res.days_to_month_end,
							want.a.res.days_to_year_end, want.a.invalid);
						$display("  got  dow=%0d eow=%b wkend=%b biz=%b",
							got.day_of_week, got.is_end_of_week, got.is_weekend,
							got.is_business_day);
						$display("       to_wk=%0d to_mo=%0d to_yr=%0d inv=%b pad=%b",
							got.days_to_week_end, got.days_to_month_end,
							got.days_to_year_end, m_tuser,
							m_tdata[gdcq_pkg::OUT_TDATA_W-1]);
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Stimulus
	initial begin
		logic [6:0] mask_v;
		logic [2:0] last_v;

		// known answers under reset registers, invalid dates, leap edges
		row_known(2000, 1, 1, 1'b0, {9'd366, 5'd31, 3'd0, 1'b0, 1'b1, 1'b1, 3'd6});
		row_known(1, 1, 1, 1'b0, {9'd365, 5'd31, 3'd5, 1'b1, 1'b0, 1'b0, 3'd1});
		row_known(9999, 12, 31, 1'b0, {9'd1, 5'd1, 3'd1, 1'b0, 1'b1, 1'b0, 3'd5});
		row_known(0, 0, 0, 1'b1, '0);
		row_known(2021, 13, 1, 1'b1, '0);
		row_known(16383, 15, 31, 1'b1, '0);
		row_known(2021, 4, 31, 1'b1, '0);
		row_known(2021, 6, 0, 1'b1, '0);
		row_known(1900, 2, 29, 1'b1, '0);
		row_known(2023, 2, 29, 1'b1, '0);
		row_pred(2000, 2, 29);
		row_pred(2024, 2, 29);
		row_pred(2023, 2, 28);
		row_pred(0, 2, 29);
		row_pred(16383, 12, 31);
		row_pred(2024, 3, 1);
		row_pred(2024, 12, 31);
		row_pred(2023, 12, 31);
		row_pred(10000, 1, 1);
		row_pred(16000, 2, 29);
		row_pred(2023, 6, 15);
		row_pred(2023, 7, 4);
		row_pred(1582, 10, 15);
		row_pred(8192, 8, 8);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_idle_pct = 38;
		rx_idle_pct = 72;
		foreach (dir_rows[i])
			send_date(dir_rows[i].d, dir_rows[i].known, dir_rows[i].a);
		s_tvalid <= 1'b0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drain();
			case (ph)
				0: begin mask_v = 7'h00; last_v = 3'd0; end
				1: begin mask_v = 7'h7f; last_v = 3'd7; end
				2: begin mask_v = 7'($urandom_range(127)); last_v = 3'($urandom_range(6)); end
				3: begin mask_v = 7'h41; last_v = 3'd6; end
				4: begin mask_v = 7'($urandom_range(127)); last_v = 3'd3; end
				default: begin
					mask_v = 7'($urandom_range(127));
					last_v = 3'($urandom_range(7));
				end
			endcase
			write_reg(gdcq_pkg::CFG_WEEKEND_MASK, mask_v);
			write_reg(gdcq_pkg::CFG_LAST_DAY, {4'($urandom_range(15)), last_v});
			// spare indexes must leave both registers alone
			if (ph == 1)
				write_reg(CFG_IDX_SPARE0, 7'($urandom_range(127)));
			else if (ph == 3)
				write_reg(CFG_IDX_SPARE1, 7'($urandom_range(127)));
			cfg_valid <= 1'b0;

			if (ph < 2) begin
				tx_idle_pct = 38;
				rx_idle_pct = 72;
			end else if (ph < 4) begin
				tx_idle_pct = 72;
				rx_idle_pct = 38;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// long receiver hold-off while dates keep coming
			if (ph == 4)
				stall_req = 1'b1;

			for (int n = 0; n < ROWS_PER_PHASE; n++)
				send_date(random_date(), 1'b0, '0);
			s_tvalid <= 1'b0;
		end

		while (answers_due.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
		if (err_cnt == 0 && answers_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
